// ----- rtl/vrtc_pkg.sv -----
// Package for the virtual RTC rate divider: sizes, event kind codes,
// the command struct sent to the terminal bank and the frequency decode.
// No dependencies.
`default_nettype none

package vrtc_pkg;

    localparam int TERMINALS       = 3;
    localparam int BASE_RATE_HZ    = 1024;
    localparam int DEFAULT_RATE_HZ = 2;

    localparam int KIND_W  = 2;
    localparam int TERM_W  = 3;
    localparam int FREQ_W  = 11;
    localparam int MASK_W  = 8;
    localparam int ALARM_W = 16;

    localparam int PER_W = (BASE_RATE_HZ > 1) ? $clog2(BASE_RATE_HZ) : 1;
    localparam int REQ_W = PER_W + 1;

    localparam int DEFAULT_COUNT_INT =
        ((BASE_RATE_HZ / DEFAULT_RATE_HZ) == 0) ? 1 : (BASE_RATE_HZ / DEFAULT_RATE_HZ);
    localparam logic [REQ_W-1:0] DEFAULT_COUNT = REQ_W'(DEFAULT_COUNT_INT);

    localparam logic [ALARM_W-1:0] ALARM_PERIOD_RESET = ALARM_W'(1024);

    localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET_FREQ = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ     = 2'd3;

    typedef struct packed {
        logic                 tick;
        logic                 open_term;
        logic                 set_freq;
        logic                 read;
        logic [TERMINALS-1:0] sel;
        logic [REQ_W-1:0]     new_count;
    } term_cmd_t;

    function automatic logic freq_valid(input logic [FREQ_W-1:0] f);
        logic ok;
        ok = (f != '0) && (32'(f) <= BASE_RATE_HZ) && ((f & (f - FREQ_W'(1))) == '0);
        return ok;
    endfunction

    // The frequency is a single set bit here, so the quotient is a shift.
    function automatic logic [REQ_W-1:0] count_for_freq(input logic [FREQ_W-1:0] f);
        logic [REQ_W-1:0] q;
        q = REQ_W'(1);
        for (int i = 0; i < FREQ_W; i++)
        begin
            if (f[i])
            begin
                q = REQ_W'(BASE_RATE_HZ >> i);
            end
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vrtc_if.sv -----
// Handshake interfaces for the event words and the result words.
// Depends on vrtc_pkg.
`default_nettype none

interface vrtc_event_if import vrtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TERM_W-1:0] terminal;
    logic [FREQ_W-1:0] frequency;

    modport source (output valid, kind, terminal, frequency, input ready);
    modport sink   (input valid, kind, terminal, frequency, output ready);
endinterface

interface vrtc_result_if import vrtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic              tick_seen;
    logic [MASK_W-1:0] fired_mask;
    logic              alarm;

    modport source (output valid, status, tick_seen, fired_mask, alarm, input ready);
    modport sink   (input valid, status, tick_seen, fired_mask, alarm, output ready);
endinterface

`default_nettype wire

// ----- rtl/vrtc_term_bank.sv -----
// Per-terminal dividers: period counters, required counts and pending flags.
// Depends on vrtc_pkg.
`default_nettype none

module vrtc_term_bank import vrtc_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire term_cmd_t            cmd,
    output logic [TERMINALS-1:0]      fired,
    output logic                      seen
);

    logic [PER_W-1:0]     period_cnt_reg  [TERMINALS];
    logic [PER_W-1:0]     period_cnt_next [TERMINALS];
    logic [REQ_W-1:0]     required_reg    [TERMINALS];
    logic [REQ_W-1:0]     required_next   [TERMINALS];
    logic [TERMINALS-1:0] pending_reg;
    logic [TERMINALS-1:0] pending_next;

    always_comb
    begin
        logic [REQ_W-1:0] inc;
        fired        = '0;
        pending_next = pending_reg;
        for (int i = 0; i < TERMINALS; i++)
        begin
            period_cnt_next[i] = period_cnt_reg[i];
            required_next[i]   = required_reg[i];
            inc = REQ_W'(period_cnt_reg[i]) + REQ_W'(1);
            if (cmd.tick)
            begin
                if (inc >= required_reg[i])
                begin
                    fired[i]           = 1'b1;
                    pending_next[i]    = 1'b1;
                    period_cnt_next[i] = '0;
                end
                else
                begin
                    period_cnt_next[i] = inc[PER_W-1:0];
                end
            end
            if (cmd.open_term && cmd.sel[i])
            begin
                period_cnt_next[i] = '0;
                pending_next[i]    = 1'b0;
                required_next[i]   = DEFAULT_COUNT;
            end
            if (cmd.set_freq && cmd.sel[i])
            begin
                required_next[i] = cmd.new_count;
            end
            if (cmd.read && cmd.sel[i])
            begin
                pending_next[i] = 1'b0;
            end
        end
    end

    assign seen = cmd.read && ((pending_reg & cmd.sel) != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            for (int i = 0; i < TERMINALS; i++)
            begin
                period_cnt_reg[i] <= '0;
                required_reg[i]   <= DEFAULT_COUNT;
            end
        end
        else
        begin
            pending_reg <= pending_next;
            for (int i = 0; i < TERMINALS; i++)
            begin
                period_cnt_reg[i] <= period_cnt_next[i];
                required_reg[i]   <= required_next[i];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vrtc_alarm.sv -----
// Global alarm counter with its programmable period register.
// Depends on vrtc_pkg.
`default_nettype none

module vrtc_alarm import vrtc_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [ALARM_W-1:0] cfg_wr_data,
    input  wire logic               tick,
    output logic                    alarm
);

    logic [ALARM_W-1:0] period_reg;
    logic [ALARM_W-1:0] count_reg;
    logic [ALARM_W-1:0] count_next;
    logic [ALARM_W:0]   inc;

    always_comb
    begin
        inc        = {1'b0, count_reg} + (ALARM_W + 1)'(1);
        count_next = count_reg;
        alarm      = 1'b0;
        if (tick)
        begin
            if (inc >= {1'b0, period_reg})
            begin
                count_next = '0;
                alarm      = 1'b1;
            end
            else
            begin
                count_next = inc[ALARM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= ALARM_PERIOD_RESET;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/virtual_rtc_rate_divider.sv -----
// Top level of the virtual RTC rate divider.
// Depends on vrtc_pkg, vrtc_if, vrtc_term_bank and vrtc_alarm.
//
// Event words arrive on evt (valid/ready): a hardware tick, an open, a set
// frequency or a read for one terminal. Every event word yields exactly one
// result word on res: status for set frequency, tick_seen for read, and
// fired_mask and alarm for a hardware tick; fields that do not apply are 0.
// The user must write the alarm period register through cfg_wr_en and
// cfg_wr_data only while no event is in flight; this is not enforced.
// An event word is registered on acceptance and processed once the result
// register can advance, when the state is updated and the result register
// is loaded. One event word is accepted per cycle as long as the result
// register drains; the throughput is set by the single state update per
// cycle in the terminal bank and the alarm counter.
// When the receiver stalls, the result register holds its word and the input
// register keeps one more; ready then drops until the result is taken.
// Reset sets every terminal to the default rate with counters and pending
// flags cleared, the alarm counter to zero and the alarm period to 1024.
`default_nettype none

module virtual_rtc_rate_divider import vrtc_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [ALARM_W-1:0] cfg_wr_data,
    vrtc_event_if.sink              evt,
    vrtc_result_if.source           res
);

    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [TERM_W-1:0] s1_term_reg;
    logic [FREQ_W-1:0] s1_freq_reg;

    logic              res_valid_reg;
    logic              res_status_reg;
    logic              res_seen_reg;
    logic [MASK_W-1:0] res_mask_reg;
    logic              res_alarm_reg;

    logic                 advance;
    logic                 go;
    logic                 term_ok;
    logic                 freq_ok;
    logic                 status_next;
    term_cmd_t            cmd;
    logic [TERMINALS-1:0] fired;
    logic                 seen;
    logic                 alarm;

    assign advance   = !res_valid_reg || res.ready;
    assign go        = s1_valid_reg && advance;
    assign evt.ready = !s1_valid_reg || advance;

    always_comb
    begin
        cmd           = '0;
        for (int i = 0; i < TERMINALS; i++)
        begin
            cmd.sel[i] = (s1_term_reg == TERM_W'(i));
        end
        term_ok       = (cmd.sel != '0);
        freq_ok       = freq_valid(s1_freq_reg);
        cmd.new_count = count_for_freq(s1_freq_reg);
        status_next   = 1'b0;
        if (go)
        begin
            case (s1_kind_reg)
                KIND_TICK:
                begin
                    cmd.tick = 1'b1;
                end
                KIND_OPEN:
                begin
                    cmd.open_term = term_ok;
                end
                KIND_SET_FREQ:
                begin
                    cmd.set_freq = term_ok && freq_ok;
                    status_next  = term_ok && !freq_ok;
                end
                KIND_READ:
                begin
                    cmd.read = term_ok;
                end
                default:
                begin
                    cmd.tick = 1'b0;
                end
            endcase
        end
    end

    vrtc_term_bank u_term_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .fired (fired),
        .seen  (seen)
    );

    vrtc_alarm u_alarm (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick        (cmd.tick),
        .alarm       (alarm)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
            begin
                s1_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            s1_kind_reg <= evt.kind;
            s1_term_reg <= evt.terminal;
            s1_freq_reg <= evt.frequency;
        end
        if (go)
        begin
            res_status_reg <= status_next;
            res_seen_reg   <= seen;
            res_mask_reg   <= MASK_W'(fired);
            res_alarm_reg  <= alarm;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.status     = res_status_reg;
    assign res.tick_seen  = res_seen_reg;
    assign res.fired_mask = res_mask_reg;
    assign res.alarm      = res_alarm_reg;

`ifndef SYNTHESIS
    a_go_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> res_valid_reg)
        else $error("processed word did not reach the result register");

    a_stalled_word_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_kind_reg))
        else $error("input register lost a word during a stall");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.tick, cmd.open_term, cmd.set_freq, cmd.read, status_next}))
        else $error("more than one command issued for one word");

    a_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_status_reg || res_seen_reg)
            |-> res_mask_reg == '0 && !res_alarm_reg)
        else $error("tick fields set on a non-tick result");

    a_no_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !go |-> cmd.tick == 1'b0 && cmd.open_term == 1'b0 && cmd.set_freq == 1'b0
            && cmd.read == 1'b0)
        else $error("state command issued without a word in progress");
`endif

endmodule

`default_nettype wire
